// ----- design/r2p_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_pkg
// Shared types, constants and the arctangent table for the rectangular to
// polar converter.
// ----------------------------------------------------------------------------
package r2p_pkg;

  // Fixed-point formats
  localparam int GUARD_BITS    = 24;
  localparam int ANG_FRAC      = 20;
  localparam int OUT_SHIFT     = 13;
  localparam int ATAN_W        = 27;
  localparam int ANG_ACC_W     = 31;
  localparam int HALF_TURN_Q20 = 180 << ANG_FRAC;
  localparam int FULL_TURN_Q20 = 360 << ANG_FRAC;
  localparam int ROUND_HALF    = 1 << (OUT_SHIFT - 1);

  // Output angle constants, 1/128 degree
  localparam int FULL_TURN_OUT = 46080;
  localparam logic [15:0] ANGLE_0   = 16'd0;
  localparam logic [15:0] ANGLE_90  = 16'd11520;
  localparam logic [15:0] ANGLE_180 = 16'd23040;
  localparam logic [15:0] ANGLE_270 = 16'd34560;

  typedef enum logic [2:0] {
    ANG_CORDIC,
    ANG_ZERO,
    ANG_DEG90,
    ANG_DEG180,
    ANG_DEG270
  } ang_code_e;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
  } rect_t;

  typedef struct packed {
    logic [15:0] angle_deg;
    logic [15:0] magnitude;
  } polar_t;

  // atan(2^-i) in degrees, scaled by 2^20
  function automatic logic [ATAN_W-1:0] atan_q20(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 27'd47185920;
      5'd1:  v = 27'd27855475;
      5'd2:  v = 27'd14718068;
      5'd3:  v = 27'd7471121;
      5'd4:  v = 27'd3750058;
      5'd5:  v = 27'd1876857;
      5'd6:  v = 27'd938658;
      5'd7:  v = 27'd469357;
      5'd8:  v = 27'd234682;
      5'd9:  v = 27'd117342;
      5'd10: v = 27'd58671;
      5'd11: v = 27'd29335;
      5'd12: v = 27'd14668;
      5'd13: v = 27'd7334;
      5'd14: v = 27'd3667;
      5'd15: v = 27'd1833;
      5'd16: v = 27'd917;
      5'd17: v = 27'd458;
      5'd18: v = 27'd229;
      5'd19: v = 27'd115;
      5'd20: v = 27'd57;
      5'd21: v = 27'd29;
      5'd22: v = 27'd14;
      5'd23: v = 27'd7;
      5'd24: v = 27'd4;
      5'd25: v = 27'd2;
      5'd26: v = 27'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/r2p_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_front
// Two entry stages: fold to the right half-plane, classify axis cases and
// square the magnitudes; then sum the squares.
// ----------------------------------------------------------------------------
module r2p_front
  import r2p_pkg::*;
#(
  parameter int W  = 16,
  parameter int XW = W + GUARD_BITS + 3,
  parameter int ZW = ANG_ACC_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  rect_t                data_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output ang_code_e            code_o,
  output logic [2*W-1:0]       s_o
);

  localparam int SW = 2 * W;

  logic                 va_q, vb_q;
  logic                 load_a, load_b, stall_a;
  logic [31:0]          x_z, y_z;
  logic signed [W-1:0]  xw, yw;
  logic signed [W:0]    cx, cy;
  logic [W-1:0]         ax, ay;
  logic                 fold;
  ang_code_e            code_d;

  logic signed [XW-1:0] xa_q, ya_q, xb_q, yb_q;
  logic signed [ZW-1:0] za_q, zb_q;
  ang_code_e            codea_q, codeb_q;
  logic [SW-1:0]        sqx_q, sqy_q, s_q;

  assign stall_a = vb_q && stall_i;
  assign stall_o = va_q && stall_a;
  assign load_a  = valid_i && !stall_o;
  assign load_b  = va_q && !stall_a;

  always_comb begin
    x_z  = {16'b0, data_i.x_value};
    y_z  = {16'b0, data_i.y_value};
    xw   = x_z[W-1:0];
    yw   = y_z[W-1:0];
    fold = xw[W-1];
    cx   = fold ? -{xw[W-1], xw} : {xw[W-1], xw};
    cy   = fold ? -{yw[W-1], yw} : {yw[W-1], yw};
    ax   = xw[W-1] ? W'(-xw) : xw;
    ay   = yw[W-1] ? W'(-yw) : yw;
    if (xw == '0) begin
      if (yw == '0) begin
        code_d = ANG_ZERO;
      end else if (yw[W-1]) begin
        code_d = ANG_DEG270;
      end else begin
        code_d = ANG_DEG90;
      end
    end else if (yw == '0) begin
      code_d = fold ? ANG_DEG180 : ANG_ZERO;
    end else begin
      code_d = ANG_CORDIC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (!stall_o) va_q <= valid_i;
      if (!stall_a) vb_q <= va_q;
    end
  end

  // Stage A: fold, guard shift, square
  always_ff @(posedge clk_i) begin
    if (load_a) begin
      xa_q    <= XW'(cx) <<< GUARD_BITS;
      ya_q    <= XW'(cy) <<< GUARD_BITS;
      za_q    <= fold ? ZW'(HALF_TURN_Q20) : '0;
      codea_q <= code_d;
      sqx_q   <= SW'(ax) * SW'(ax);
      sqy_q   <= SW'(ay) * SW'(ay);
    end
  end

  // Stage B: sum of squares
  always_ff @(posedge clk_i) begin
    if (load_b) begin
      xb_q    <= xa_q;
      yb_q    <= ya_q;
      zb_q    <= za_q;
      codeb_q <= codea_q;
      s_q     <= sqx_q + sqy_q;
    end
  end

  assign valid_o = vb_q;
  assign x_o     = xb_q;
  assign y_o     = yb_q;
  assign z_o     = zb_q;
  assign code_o  = codeb_q;
  assign s_o     = s_q;

endmodule

// ----- design/r2p_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_cell
// One link of the chain: one CORDIC vectoring rotation and one digit of the
// square root, each present only where the cell index calls for it.
// ----------------------------------------------------------------------------
module r2p_cell
  import r2p_pkg::*;
#(
  parameter int W     = 16,
  parameter int STEPS = 16,
  parameter int IDX   = 0,
  parameter int XW    = W + GUARD_BITS + 3,
  parameter int ZW    = ANG_ACC_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  ang_code_e            code_i,
  input  logic [2*W-1:0]       s_i,
  input  logic [W:0]           rem_i,
  input  logic [W-1:0]         root_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output ang_code_e            code_o,
  output logic [2*W-1:0]       s_o,
  output logic [W:0]           rem_o,
  output logic [W-1:0]         root_o
);

  localparam bit DO_ROT  = (IDX < STEPS) && (IDX < 32);
  localparam bit DO_SQRT = (IDX < W);

  logic                 valid_q, load;
  logic signed [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] at, z_d, z_q;
  ang_code_e            code_q;
  logic [2*W-1:0]       s_d, s_q;
  logic [W+2:0]         rem_t, trial, diff;
  logic                 ge;
  logic [W:0]           rem_d, rem_q;
  logic [W-1:0]         root_d, root_q;

  assign stall_o = valid_q && stall_i;
  assign load    = valid_i && !stall_o;

  always_comb begin
    xs  = x_i >>> IDX;
    ys  = y_i >>> IDX;
    at  = ZW'(atan_q20(5'(IDX)));
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    if (DO_ROT) begin
      if (!y_i[XW-1]) begin
        x_d = x_i + ys;
        y_d = y_i - xs;
        z_d = z_i + at;
      end else begin
        x_d = x_i - ys;
        y_d = y_i + xs;
        z_d = z_i - at;
      end
    end
  end

  always_comb begin
    rem_t  = {rem_i, s_i[2*W-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = rem_t >= trial;
    diff   = rem_t - trial;
    rem_d  = rem_i;
    root_d = root_i;
    s_d    = s_i;
    if (DO_SQRT) begin
      rem_d  = ge ? diff[W:0] : rem_t[W:0];
      root_d = {root_i[W-2:0], ge};
      s_d    = s_i << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      code_q <= code_i;
      s_q    <= s_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign code_o  = code_q;
  assign s_o     = s_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

// ----- design/r2p_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_out
// Output register: wrap and round the angle, round and saturate the
// magnitude, substitute axis cases.
// ----------------------------------------------------------------------------
module r2p_out
  import r2p_pkg::*;
#(
  parameter int W  = 16,
  parameter int ZW = ANG_ACC_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic signed [ZW-1:0] z_i,
  input  ang_code_e            code_i,
  input  logic [W:0]           rem_i,
  input  logic [W-1:0]         root_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output polar_t               data_o
);

  localparam int AW = ZW - OUT_SHIFT;

  logic                 valid_q, load;
  logic signed [ZW-1:0] z_pos, z_rnd;
  logic [AW-1:0]        ang_w, ang_m;
  logic [15:0]          angle;
  logic                 round_up;
  logic [32:0]          mag_x;
  polar_t               data_d, data_q;

  assign stall_o = valid_q && stall_i;
  assign load    = valid_i && !stall_o;

  always_comb begin
    z_pos    = z_i[ZW-1] ? z_i + ZW'(FULL_TURN_Q20) : z_i;
    z_rnd    = z_pos + ZW'(ROUND_HALF);
    ang_w    = z_rnd[ZW-1:OUT_SHIFT];
    ang_m    = (ang_w >= AW'(FULL_TURN_OUT)) ? ang_w - AW'(FULL_TURN_OUT) : ang_w;
    case (code_i)
      ANG_ZERO:   angle = ANGLE_0;
      ANG_DEG90:  angle = ANGLE_90;
      ANG_DEG180: angle = ANGLE_180;
      ANG_DEG270: angle = ANGLE_270;
      default:    angle = ang_m[15:0];
    endcase
    round_up = rem_i > {1'b0, root_i};
    mag_x    = 33'(root_i) + 33'(round_up);
    data_d.angle_deg = angle;
    data_d.magnitude = (mag_x > 33'd65535) ? 16'hFFFF : mag_x[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/rect_to_polar_degrees_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_to_polar_degrees_core
// Rectangular to polar converter: angle in 1/128 degree over [0, 360) and
// rounded vector length, one coordinate pair per cycle while out_stall_i is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one (x, y)
//   pair per transaction; output channel out_valid_o / out_stall_i /
//   out_data_o carries the matching (angle, magnitude) transaction. Results
//   leave in input order.
//   Pipeline: two entry stages (fold and square, sum), one chain cell per
//   rotation / root digit (CELLS = max(CORDIC_STEPS, COORD_WIDTH) cells),
//   one output register.
//   Throughput: one transaction per cycle while out_stall_i is low. Every stage holds its own valid
//   bit, so a stalled receiver only stops the stages that are full; empty
//   stages keep filling and input is taken until the chain is packed.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   Axis inputs bypass the rotation result: x = 0 gives 90 or 270 degrees
//   (origin gives 0), y = 0 gives 0 or 180 degrees.
// ----------------------------------------------------------------------------
module rect_to_polar_degrees_core
  import r2p_pkg::*;
#(
  parameter int COORD_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  rect_t  in_data_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output polar_t out_data_o
);

  localparam int W     = COORD_WIDTH;
  localparam int XW    = W + GUARD_BITS + 3;
  localparam int ZW    = ANG_ACC_W;
  localparam int CELLS = (CORDIC_STEPS > W) ? CORDIC_STEPS : W;

  // Chain taps: index k feeds cell k, index CELLS feeds the output stage
  logic                 valid_c [CELLS+1];
  logic                 stall_c [CELLS+1];
  logic signed [XW-1:0] x_c     [CELLS+1];
  logic signed [XW-1:0] y_c     [CELLS+1];
  logic signed [ZW-1:0] z_c     [CELLS+1];
  ang_code_e            code_c  [CELLS+1];
  logic [2*W-1:0]       s_c     [CELLS+1];
  logic [W:0]           rem_c   [CELLS+1];
  logic [W-1:0]         root_c  [CELLS+1];

  // Fold, classify and square, then sum the squares
  r2p_front #(
    .W  (W),
    .XW (XW),
    .ZW (ZW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (valid_c[0]),
    .stall_i (stall_c[0]),
    .x_o     (x_c[0]),
    .y_o     (y_c[0]),
    .z_o     (z_c[0]),
    .code_o  (code_c[0]),
    .s_o     (s_c[0])
  );

  // Square root recurrence starts from an empty root and remainder
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  // Chain of rotation / root-digit cells
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    r2p_cell #(
      .W     (W),
      .STEPS (CORDIC_STEPS),
      .IDX   (k),
      .XW    (XW),
      .ZW    (ZW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .stall_o (stall_c[k]),
      .x_i     (x_c[k]),
      .y_i     (y_c[k]),
      .z_i     (z_c[k]),
      .code_i  (code_c[k]),
      .s_i     (s_c[k]),
      .rem_i   (rem_c[k]),
      .root_i  (root_c[k]),
      .valid_o (valid_c[k+1]),
      .stall_i (stall_c[k+1]),
      .x_o     (x_c[k+1]),
      .y_o     (y_c[k+1]),
      .z_o     (z_c[k+1]),
      .code_o  (code_c[k+1]),
      .s_o     (s_c[k+1]),
      .rem_o   (rem_c[k+1]),
      .root_o  (root_c[k+1])
    );
  end

  // Round, wrap, saturate and hold the result for the receiver
  r2p_out #(
    .W  (W),
    .ZW (ZW)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[CELLS]),
    .stall_o (stall_c[CELLS]),
    .z_i     (z_c[CELLS]),
    .code_i  (code_c[CELLS]),
    .rem_i   (rem_c[CELLS]),
    .root_i  (root_c[CELLS]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule
